// ===== rtl/gshs_pkg.sv =====
// Shared types and constants for the Gauss-Seidel heat sweep core.
// No dependencies; imported by every other file of the block except gshs_queue.
package gshs_pkg;

    // Fixed field and register widths
    localparam int ROW_W        = 17;
    localparam int COL_OUT_W    = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int WIDTH_REG_W  = 10;
    localparam int HEIGHT_REG_W = 16;

    // Register reset values (interior size)
    localparam int RESET_INTERIOR_W = 1022;
    localparam int RESET_INTERIOR_H = 1022;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERIOR_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERIOR_HEIGHT = 2'd1;

    // Classification of one accepted cell, handed from front to back
    typedef struct packed {
        logic             first_row;  // row 0: fill line stores only
        logic             border;     // value passes through from the old row
        logic             last_row;   // also emit the cell itself
        logic             last_col;   // end of a padded row
        logic [ROW_W-1:0] row;
    } t_ctl;

endpackage

// ===== rtl/gshs_queue.sv =====
// Small FIFO that decouples the front classifier from the back sweep unit.
// Depends on no package; width and depth come from the instantiating level.
module gshs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count, n_count;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        if (p == PtrW'(DEPTH - 1)) begin
            return '0;
        end
        return p + PtrW'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CntW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

// ===== rtl/gshs_front.sv =====
// Front end: configuration registers, raster counters and cell classification.
// Depends on gshs_pkg; feeds gshs_queue.
module gshs_front #(
    parameter  int MAX_COLS  = 1024,
    parameter  int CELL_BITS = 32,
    localparam int ColW      = $clog2(MAX_COLS)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gshs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gshs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [CELL_BITS-1:0]        i_cell_value,
    input  logic                               i_full,
    output logic                               o_push,
    output gshs_pkg::t_ctl                     o_ctl,
    output logic [ColW-1:0]                    o_col,
    output logic [CELL_BITS-1:0]               o_cell
);
    import gshs_pkg::*;

    localparam int MaxInterior  = MAX_COLS - 2;
    localparam int ResetLastCol =
        ((RESET_INTERIOR_W > MaxInterior) ? MaxInterior : RESET_INTERIOR_W) + 1;

    // Index of the last padded column / row, i.e. W-1 and H-1
    logic [ColW-1:0]  r_last_col, n_last_col;
    logic [ROW_W-1:0] r_last_row, n_last_row;
    logic [ColW-1:0]  r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             accept;
    logic             last_col;
    logic             last_row;

    function automatic logic [ColW-1:0] col_limit(input logic [WIDTH_REG_W-1:0] w);
        if (w == '0) begin
            return ColW'(2);
        end else if (int'(w) > MaxInterior) begin
            return ColW'(MaxInterior + 1);
        end
        return ColW'(int'(w) + 1);
    endfunction

    function automatic logic [ROW_W-1:0] row_limit(input logic [HEIGHT_REG_W-1:0] h);
        if (h == '0) begin
            return ROW_W'(2);
        end
        return ROW_W'(h) + ROW_W'(1);
    endfunction

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INTERIOR_WIDTH:  n_last_col = col_limit(i_cfg_data[WIDTH_REG_W-1:0]);
                CFG_INTERIOR_HEIGHT: n_last_row = row_limit(i_cfg_data[HEIGHT_REG_W-1:0]);
                default: ;
            endcase
        end
    end

    assign accept   = i_valid && !i_full;
    assign last_col = (r_col >= r_last_col);
    assign last_row = (r_row >= r_last_row);

    // Advance the raster position; wrap at the end of a row and of the grid
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + ColW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= ColW'(ResetLastCol);
            r_last_row <= ROW_W'(RESET_INTERIOR_H + 1);
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

    assign o_stall         = i_full;
    assign o_push          = accept;
    assign o_col           = r_col;
    assign o_cell          = i_cell_value;
    assign o_ctl.first_row = (r_row == '0);
    assign o_ctl.border    = (r_row == ROW_W'(1)) || (r_col == '0) || last_col;
    assign o_ctl.last_row  = last_row;
    assign o_ctl.last_col  = last_col;
    assign o_ctl.row       = r_row;

endmodule

// ===== rtl/gshs_back.sv =====
// Back end: line stores, four-point stencil update and the result buffer.
// Depends on gshs_pkg; drains gshs_queue and drives the result channel.
module gshs_back #(
    parameter  int MAX_COLS  = 1024,
    parameter  int CELL_BITS = 32,
    localparam int ColW      = $clog2(MAX_COLS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  gshs_pkg::t_ctl                    i_ctl,
    input  logic [ColW-1:0]                   i_col,
    input  logic [CELL_BITS-1:0]              i_cell,
    output logic                              o_q_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [gshs_pkg::ROW_W-1:0]        o_out_row,
    output logic [gshs_pkg::COL_OUT_W-1:0]    o_out_col,
    output logic signed [CELL_BITS-1:0]       o_out_value,
    output logic                              o_grid_done
);
    import gshs_pkg::*;

    localparam int SumW = CELL_BITS + 2;

    // Line stores: original values of the previous row, updated values of it
    logic [CELL_BITS-1:0] r_old_store [MAX_COLS];
    logic [CELL_BITS-1:0] r_new_store [MAX_COLS];

    logic [CELL_BITS-1:0] r_rd_new, r_rd_old, r_rd_right;
    logic                 r_s2_valid;
    t_ctl                 r_s2_ctl;
    logic [ColW-1:0]      r_s2_col;
    logic [CELL_BITS-1:0] r_s2_cell;
    logic [CELL_BITS-1:0] r_left, n_left;

    logic                 r_o_valid, n_o_valid;
    logic [ROW_W-1:0]     r_o_row, n_o_row;
    logic [COL_OUT_W-1:0] r_o_col, n_o_col;
    logic [CELL_BITS-1:0] r_o_val, n_o_val;
    logic                 r_o_done, n_o_done;
    logic                 r_p_valid, n_p_valid;
    logic [ROW_W-1:0]     r_p_row, n_p_row;
    logic [COL_OUT_W-1:0] r_p_col, n_p_col;
    logic [CELL_BITS-1:0] r_p_val, n_p_val;
    logic                 r_p_done, n_p_done;

    logic [ColW-1:0]      col_right;
    logic [SumW-1:0]      sum;
    logic [SumW-1:0]      sum_adj;
    logic [CELL_BITS-1:0] quot;
    logic [CELL_BITS-1:0] val;
    logic                 can_load;
    logic                 s2_fire;
    logic                 load;
    logic                 take;

    function automatic logic [SumW-1:0] sext(input logic [CELL_BITS-1:0] x);
        return {{(SumW - CELL_BITS){x[CELL_BITS-1]}}, x};
    endfunction

    assign col_right = (i_col == ColW'(MAX_COLS - 1)) ? '0 : i_col + ColW'(1);

    // Truncate toward zero: bias negative sums by three before the shift
    assign sum     = sext(r_rd_new) + sext(r_left) + sext(r_rd_right) + sext(r_s2_cell);
    assign sum_adj = sum + {{(SumW - 2){1'b0}}, sum[SumW-1], sum[SumW-1]};
    assign quot    = sum_adj[SumW-1:2];
    assign val     = r_s2_ctl.border ? r_rd_old : quot;

    assign take     = r_o_valid && !i_stall;
    assign can_load = !r_p_valid && (!r_o_valid || !i_stall);
    assign s2_fire  = r_s2_valid && (r_s2_ctl.first_row || can_load);
    assign load     = s2_fire && !r_s2_ctl.first_row;
    assign o_q_pop  = i_q_valid && (!r_s2_valid || s2_fire);
    assign n_left   = load ? val : r_left;

    always_comb begin
        n_o_valid = r_o_valid;
        n_o_row   = r_o_row;
        n_o_col   = r_o_col;
        n_o_val   = r_o_val;
        n_o_done  = r_o_done;
        n_p_valid = r_p_valid;
        n_p_row   = r_p_row;
        n_p_col   = r_p_col;
        n_p_val   = r_p_val;
        n_p_done  = r_p_done;
        if (load) begin
            n_o_valid = 1'b1;
            n_o_row   = r_s2_ctl.row - ROW_W'(1);
            n_o_col   = COL_OUT_W'(r_s2_col);
            n_o_val   = val;
            n_o_done  = 1'b0;
            // Last row: hold the cell itself as a second result
            n_p_valid = r_s2_ctl.last_row;
            n_p_row   = r_s2_ctl.row;
            n_p_col   = COL_OUT_W'(r_s2_col);
            n_p_val   = r_s2_cell;
            n_p_done  = r_s2_ctl.last_col;
        end else if (take) begin
            n_o_valid = r_p_valid;
            n_o_row   = r_p_row;
            n_o_col   = r_p_col;
            n_o_val   = r_p_val;
            n_o_done  = r_p_done;
            n_p_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_p_valid  <= 1'b0;
            r_left     <= '0;
        end else begin
            if (o_q_pop) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            r_o_valid <= n_o_valid;
            r_p_valid <= n_p_valid;
            r_left    <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s2_ctl  <= i_ctl;
            r_s2_col  <= i_col;
            r_s2_cell <= i_cell;
        end
        r_o_row  <= n_o_row;
        r_o_col  <= n_o_col;
        r_o_val  <= n_o_val;
        r_o_done <= n_o_done;
        r_p_row  <= n_p_row;
        r_p_col  <= n_p_col;
        r_p_val  <= n_p_val;
        r_p_done <= n_p_done;
    end

    // Reads issue on pop, writes land when the cell retires; a pop never
    // reads a column that the retiring cell writes in the same cycle
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rd_new   <= r_new_store[i_col];
            r_rd_old   <= r_old_store[i_col];
            r_rd_right <= r_old_store[col_right];
        end
        if (s2_fire) begin
            r_old_store[r_s2_col] <= r_s2_cell;
            r_new_store[r_s2_col] <= r_s2_ctl.first_row ? r_s2_cell : val;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_row   = r_o_row;
    assign o_out_col   = r_o_col;
    assign o_out_value = r_o_val;
    assign o_grid_done = r_o_done;

endmodule

// ===== rtl/gauss_seidel_heat_sweep_core.sv =====
// Top level of the Gauss-Seidel heat sweep: front classifier, queue, back unit.
// Depends on gshs_pkg, gshs_front, gshs_queue and gshs_back.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------
//  cells   | in        | i_valid / o_stall          | i_cell_value
//  results | out       | o_valid / i_stall          | o_out_row o_out_col o_out_value
//          |           |                            | o_grid_done
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// One cell is taken per cycle while the queue has room; its first result leaves through
// the queue, the stage-two register and the result register. Cells of the last row each
// give two results, so on that row the next cell waits for the single result port.
// Reset clears counters and control; line stores hold nothing until row 0 fills them.
// A stalled result port backs up through the four-entry queue to o_stall.
module gauss_seidel_heat_sweep_core #(
    parameter int MAX_COLS  = 1024,
    parameter int CELL_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gshs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gshs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [CELL_BITS-1:0]        i_cell_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [gshs_pkg::ROW_W-1:0]         o_out_row,
    output logic [gshs_pkg::COL_OUT_W-1:0]     o_out_col,
    output logic signed [CELL_BITS-1:0]        o_out_value,
    output logic                               o_grid_done
);
    import gshs_pkg::*;

    localparam int ColW = $clog2(MAX_COLS);
    localparam int QW   = $bits(t_ctl) + ColW + CELL_BITS;

    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_valid;
    t_ctl                 f_ctl;
    logic [ColW-1:0]      f_col;
    logic [CELL_BITS-1:0] f_cell;
    t_ctl                 b_ctl;
    logic [ColW-1:0]      b_col;
    logic [CELL_BITS-1:0] b_cell;

    gshs_front #(
        .MAX_COLS  (MAX_COLS),
        .CELL_BITS (CELL_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cell_value (i_cell_value),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_ctl        (f_ctl),
        .o_col        (f_col),
        .o_cell       (f_cell)
    );

    gshs_queue #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_ctl, f_col, f_cell}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  ({b_ctl, b_col, b_cell})
    );

    gshs_back #(
        .MAX_COLS  (MAX_COLS),
        .CELL_BITS (CELL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_ctl       (b_ctl),
        .i_col       (b_col),
        .i_cell      (b_cell),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_grid_done (o_grid_done)
    );

endmodule

// ===== rtl/gshs_checker.sv =====
// Port-level checks on the result channel of the heat sweep core.
// Depends on gshs_pkg; bound to gauss_seidel_heat_sweep_core below.
module gshs_checker #(
    parameter int CELL_BITS = 32
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [gshs_pkg::ROW_W-1:0]        o_out_row,
    input logic [gshs_pkg::COL_OUT_W-1:0]    o_out_col,
    input logic signed [CELL_BITS-1:0]       o_out_value,
    input logic                              o_grid_done
);
    import gshs_pkg::*;

    // Reset empties the result buffer
    a_reset_drains: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid one cycle after reset");

    // A stalled result stays up with the same value
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_value))
        else $error("stalled result dropped or changed");

    // The final cell sits on the last padded column, never column zero
    a_done_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_grid_done |-> o_out_col != '0)
        else $error("grid done flagged on column zero");

    // The final cell belongs to the last row, which is never row zero
    a_done_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_grid_done |-> o_out_row != '0)
        else $error("grid done flagged on row zero");

endmodule

bind gauss_seidel_heat_sweep_core gshs_checker #(
    .CELL_BITS (CELL_BITS)
) u_gshs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_row   (o_out_row),
    .o_out_col   (o_out_col),
    .o_out_value (o_out_value),
    .o_grid_done (o_grid_done)
);

// ===== tb/sv/tb_gauss_seidel_heat_sweep_core.sv =====
// Self-checking bench for gauss_seidel_heat_sweep_core: streams padded grids, predicts
// every swept cell with a line-store model of its own and compares each output transfer.
// Depends on gshs_pkg and gauss_seidel_heat_sweep_core.
module tb_gauss_seidel_heat_sweep_core;
    import gshs_pkg::*;

    localparam int LINE_CELLS     = 1024;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CELLS   = 260;
    localparam int HOLD_OFF_LONG  = 150;
    localparam int PART_ROW_CELLS = 40;
    localparam int NARROW_W       = 30;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic [31:0]          value;
        logic                 done;
    } t_swept_cell;

    // Tracks the sweep: line stores, counters, registers and the cells still owed.
    class gs_sweep_tracker;
        logic [31:0]             old_line [LINE_CELLS];
        logic [31:0]             new_line [LINE_CELLS];
        logic [31:0]             left_new;
        int unsigned             col_cnt;
        int unsigned             row_cnt;
        logic [WIDTH_REG_W-1:0]  width_reg;
        logic [HEIGHT_REG_W-1:0] height_reg;
        t_swept_cell             swept_cells [$];
        int                      mismatches;

        function new();
            left_new   = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            width_reg  = WIDTH_REG_W'(RESET_INTERIOR_W);
            height_reg = HEIGHT_REG_W'(RESET_INTERIOR_H);
            mismatches = 0;
        endfunction

        function int unsigned padded_w();
            int unsigned w;
            w = width_reg;
            if (w < 1) w = 1;
            if (w > LINE_CELLS - 2) w = LINE_CELLS - 2;
            return w + 2;
        endfunction

        function int unsigned padded_h();
            int unsigned h;
            h = height_reg;
            if (h < 1) h = 1;
            return h + 2;
        endfunction

        function bit at_grid_start();
            return col_cnt == 0 && row_cnt == 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INTERIOR_WIDTH:  width_reg  = data[WIDTH_REG_W-1:0];
                CFG_INTERIOR_HEIGHT: height_reg = data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_cell(logic [31:0] cell_val);
            int unsigned c;
            int unsigned r;
            bit          last_col;
            bit          last_row;
            longint      sum;
            logic [31:0] val;
            t_swept_cell e;
            c        = col_cnt;
            r        = row_cnt;
            last_col = c >= padded_w() - 1;
            last_row = r >= padded_h() - 1;
            if (c > LINE_CELLS - 1) c = LINE_CELLS - 1;
            if (r == 0) begin
                old_line[c] = cell_val;
                new_line[c] = cell_val;
            end else begin
                if (r == 1 || c == 0 || last_col) begin
                    val = old_line[c];
                end else begin
                    // upper and left are already swept, right and lower are not
                    sum = $signed(new_line[c]);
                    sum += $signed(left_new);
                    sum += $signed(old_line[c + 1]);
                    sum += $signed(cell_val);
                    val = 32'(sum / 4);
                end
                new_line[c] = val;
                left_new    = val;
                old_line[c] = cell_val;
                e.row   = ROW_W'(r - 1);
                e.col   = COL_OUT_W'(c);
                e.value = val;
                e.done  = 1'b0;
                swept_cells.push_back(e);
                if (last_row) begin
                    e.row   = ROW_W'(r);
                    e.value = cell_val;
                    e.done  = last_col;
                    swept_cells.push_back(e);
                end
            end
            if (last_col) begin
                col_cnt = 0;
                row_cnt = last_row ? 0 : ((r + 1) & 32'h1FFFF);
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void check_result(logic [ROW_W-1:0] row, logic [COL_OUT_W-1:0] col,
                                   logic [31:0] value, logic done);
            t_swept_cell e;
            if (swept_cells.size() == 0) begin
                $display("%0t: result row %0d col %0d value %0d with nothing expected",
                         $time, row, col, $signed(value));
                mismatches++;
                return;
            end
            e = swept_cells.pop_front();
            if (row !== e.row) begin
                $display("%0t: out_row expected %0d, actual %0d", $time, e.row, row);
                mismatches++;
            end
            if (col !== e.col) begin
                $display("%0t: out_col expected %0d, actual %0d", $time, e.col, col);
                mismatches++;
            end
            if (value !== e.value) begin
                $display("%0t: out_value at row %0d col %0d expected %0d, actual %0d",
                         $time, e.row, e.col, $signed(e.value), $signed(value));
                mismatches++;
            end
            if (done !== e.done) begin
                $display("%0t: grid_done at row %0d col %0d expected %0b, actual %0b",
                         $time, e.row, e.col, e.done, done);
                mismatches++;
            end
        endfunction

        function int close_out();
            if (swept_cells.size() != 0)
                $display("%0t: %0d swept cells never arrived", $time, swept_cells.size());
            return mismatches + swept_cells.size();
        endfunction
    endclass

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_cfg_valid  = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data   = '0;
    logic                    i_valid      = 1'b0;
    logic                    o_stall;
    logic signed [31:0]      i_cell_value = '0;
    logic                    o_valid;
    logic                    i_stall      = 1'b0;
    logic [ROW_W-1:0]        o_out_row;
    logic [COL_OUT_W-1:0]    o_out_col;
    logic signed [31:0]      o_out_value;
    logic                    o_grid_done;

    gs_sweep_tracker sweep;
    int              burst_left      = 0;
    bit              hold_off_req    = 1'b0;
    bit              hold_off_used   = 1'b0;
    int              hold_off_left   = 0;
    int              stall_mode      = 0;
    int              stall_mode_left = 0;
    int              quiet_cycles    = 0;

    gauss_seidel_heat_sweep_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cell_value(i_cell_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_grid_done (o_grid_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sweep.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold the cell until the transfer happens.
    task automatic push_cell(input logic [31:0] cell_val);
        i_valid      <= 1'b1;
        i_cell_value <= cell_val;
        do @(posedge i_clk); while (o_stall);
        sweep.note_cell(cell_val);
    endtask

    task automatic feed_cell(input logic [31:0] cell_val);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        push_cell(cell_val);
    endtask

    task automatic feed_row3(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c);
        feed_cell(a);
        feed_cell(b);
        feed_cell(c);
    endtask

    // Drop valid, wait for every owed cell, then let the pipeline empty out.
    task automatic settle();
        i_valid <= 1'b0;
        while (sweep.swept_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_cell();
        case ($urandom_range(0, 6))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($urandom_range(0, 16)) - 32'd8;
            3:       return 32'h7FFF_FFF0 + 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // Result side: check each transfer, then pick the stall for the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sweep.check_result(o_out_row, o_out_col, o_out_value, o_grid_done);
        if (hold_off_req && !hold_off_used) begin
            hold_off_used = 1'b1;
            hold_off_left = HOLD_OFF_LONG;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_stall <= 1'b1;
        end else begin
            if (stall_mode_left == 0) begin
                stall_mode      = $urandom_range(0, 3);
                stall_mode_left = $urandom_range(20, 200);
            end else begin
                stall_mode_left--;
            end
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= ~i_stall;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int unsigned random_cells;
        int unsigned n_cells;
        int unsigned change_at;
        int unsigned grid_cells;
        int unsigned w;
        int unsigned h;
        bit          mid_change;
        logic [CFG_DATA_W-1:0] wdata;

        sweep = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest grid, width zero with junk upper bits: swept cell is all-minimum.
        write_reg(CFG_INTERIOR_WIDTH, 16'hFC00);
        write_reg(CFG_INTERIOR_HEIGHT, 16'd1);
        feed_row3(32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555);
        feed_row3(32'h8000_0000, 32'hAAAA_AAAA, 32'h8000_0000);
        feed_row3(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        settle();

        // Height zero; swept sum is -3, which must truncate to zero, not round down.
        write_reg(CFG_INTERIOR_WIDTH, 16'd1);
        write_reg(CFG_INTERIOR_HEIGHT, 16'd0);
        feed_row3(32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        feed_row3(32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'd0);
        feed_row3(32'h8000_0000, 32'd0, 32'hFFFF_FFFF);
        settle();

        // Widest rows and tallest grid, narrowed partway into row 0, then cut both short.
        write_reg(CFG_INTERIOR_WIDTH, 16'hFFFF);
        write_reg(CFG_INTERIOR_HEIGHT, 16'hFFFF);
        repeat (PART_ROW_CELLS) feed_cell(pick_cell());
        settle();
        // column count is past the new end: the next cell closes row 0
        write_reg(CFG_INTERIOR_WIDTH, 16'(NARROW_W));
        hold_off_req <= 1'b1;
        repeat (2 * (NARROW_W + 2) + 7) feed_cell(pick_cell());
        settle();
        write_reg(CFG_INTERIOR_WIDTH, 16'd0);
        write_reg(CFG_INTERIOR_HEIGHT, 16'd0);
        // column and row counts are both past the new ends: one cell closes the grid
        feed_cell(pick_cell());
        settle();

        random_cells = 0;
        while (random_cells < RANDOM_CELLS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 5);
            wdata = 16'(w);
            if ($urandom_range(0, 3) == 0) wdata[15:10] = 6'($urandom);
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_INTERIOR_WIDTH, wdata);
                write_reg(CFG_INTERIOR_HEIGHT, 16'(h));
            end else begin
                write_reg(CFG_INTERIOR_HEIGHT, 16'(h));
                write_reg(CFG_INTERIOR_WIDTH, wdata);
            end
            n_cells    = sweep.padded_w() * sweep.padded_h();
            mid_change = ($urandom_range(0, 3) == 0);
            change_at  = $urandom_range(1, n_cells - 1);
            grid_cells = 0;
            do begin
                feed_cell(pick_cell());
                random_cells++;
                grid_cells++;
                if (mid_change && grid_cells == change_at) begin
                    settle();
                    // only shrink the width mid-grid so no unfilled line entry is read
                    if ($urandom_range(0, 1) == 1)
                        write_reg(CFG_INTERIOR_WIDTH,
                                  16'($urandom_range(0, sweep.padded_w() - 2)));
                    else
                        write_reg(CFG_INTERIOR_HEIGHT, 16'($urandom_range(0, 8)));
                    mid_change = 1'b0;
                end
            end while (!sweep.at_grid_start());
            settle();
        end

        if (sweep.close_out() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gshs_pkg.sv
rtl/gshs_queue.sv
rtl/gshs_front.sv
rtl/gshs_back.sv
rtl/gauss_seidel_heat_sweep_core.sv
rtl/gshs_checker.sv
tb/sv/tb_gauss_seidel_heat_sweep_core.sv
